// ----- rtl/pgld_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the PCM gain, limiter and declick block.
// No dependencies.
package pgld_pkg;

  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_START  = 2'd1,
    CMD_FINISH = 2'd2,
    CMD_INTR   = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t               cmd;
    logic signed [15:0] sample;
  } qent_t;

  typedef struct packed {
    logic [8:0] vol;
    logic [6:0] limit_pct;
    logic [6:0] fade_len;
  } cfg_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_LIM_GO,
    B_LIM_WAIT,
    B_SCL_GO,
    B_SCL_WAIT,
    B_RMP_GO,
    B_RMP_WAIT,
    B_SMP_OUT,
    B_FADE_GO,
    B_FADE_WAIT,
    B_FADE_OUT
  } bst_t;

  typedef enum logic [1:0] {
    REG_VOL  = 2'd0,
    REG_LIM  = 2'd1,
    REG_FADE = 2'd2,
    REG_NONE = 2'd3
  } reg_t;

  localparam int          MAX_RAMP_DEF = 64;
  localparam int          QDEPTH       = 4;
  localparam int          QAW          = 2;
  localparam int          DIV_W        = 25;
  localparam int          CFG_AW       = 4;
  localparam int          OUT_W        = 112;
  localparam logic [8:0]  VOL_RST      = 9'd100;
  localparam logic [6:0]  LIM_RST      = 7'd100;
  localparam logic [6:0]  FADE_RST     = 7'd64;
  // ceil(2^31 / 100): exact floor division by 100 for operands below 2^24
  localparam logic [24:0] PCT_RECIP    = 25'd21474837;
  localparam int          RECIP_SH     = 31;
  localparam logic [15:0] FULL_SCALE   = 16'd32767;

endpackage

// ----- rtl/pgld_front.sv -----
`timescale 1ns / 1ps
// Front part: input beat acceptance, command decode and configuration registers.
// Depends on pgld_pkg.
module pgld_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [15:0]                 in_tdata,   // sample_in
  input  logic [1:0]                  in_tuser,   // command
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [pgld_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready,
  input  logic                        q_full,
  output logic                        q_push,
  output pgld_pkg::qent_t             q_wdata,
  output pgld_pkg::cfg_t              cfg
);

  logic [8:0]     vol_r;
  logic [6:0]     lim_r;
  logic [6:0]     fade_r;
  pgld_pkg::reg_t sel;
  logic           wr;

  assign cfg_pready = 1'b1;
  assign sel        = pgld_pkg::reg_t'(cfg_paddr[3:2]);
  assign wr         = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vol_r  <= pgld_pkg::VOL_RST;
      lim_r  <= pgld_pkg::LIM_RST;
      fade_r <= pgld_pkg::FADE_RST;
    end else if (wr) begin
      unique case (sel)
        pgld_pkg::REG_VOL:  vol_r  <= cfg_pwdata[8:0];
        pgld_pkg::REG_LIM:  lim_r  <= cfg_pwdata[6:0];
        pgld_pkg::REG_FADE: fade_r <= cfg_pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      pgld_pkg::REG_VOL:  cfg_prdata = {23'd0, vol_r};
      pgld_pkg::REG_LIM:  cfg_prdata = {25'd0, lim_r};
      pgld_pkg::REG_FADE: cfg_prdata = {25'd0, fade_r};
      default:            cfg_prdata = 32'd0;
    endcase
  end

  assign cfg.vol       = vol_r;
  assign cfg.limit_pct = lim_r;
  assign cfg.fade_len  = fade_r;

  assign in_tready      = !q_full;
  assign q_push         = in_tvalid & in_tready;
  assign q_wdata.cmd    = pgld_pkg::cmd_t'(in_tuser);
  assign q_wdata.sample = in_tdata;

endmodule

// ----- rtl/pgld_queue.sv -----
`timescale 1ns / 1ps
// Short command queue between the front and back parts.
// Depends on pgld_pkg.
module pgld_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  pgld_pkg::qent_t wdata,
  output logic            full,
  input  logic            pop,
  output logic            valid,
  output pgld_pkg::qent_t rdata
);

  pgld_pkg::qent_t              mem_r [pgld_pkg::QDEPTH];
  logic [pgld_pkg::QAW-1:0]     wp_r, rp_r;
  logic [pgld_pkg::QAW:0]       cnt_r;
  logic                         do_pop;

  assign full   = (cnt_r == (pgld_pkg::QAW+1)'(pgld_pkg::QDEPTH));
  assign valid  = (cnt_r != '0);
  assign rdata  = mem_r[rp_r];
  assign do_pop = pop & valid;

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push)   wp_r <= wp_r + 1'b1;
      if (do_pop) rp_r <= rp_r + 1'b1;
      if (push && !do_pop)      cnt_r <= cnt_r + 1'b1;
      else if (!push && do_pop) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

// ----- rtl/pgld_div.sv -----
`timescale 1ns / 1ps
// Restoring serial divider, one quotient bit per cycle, 7-bit divisor.
// Depends on pgld_pkg.
module pgld_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [pgld_pkg::DIV_W-1:0] dividend,
  input  logic [6:0]                 divisor,
  output logic                       done,
  output logic [pgld_pkg::DIV_W-1:0] quo
);

  localparam int CW = $clog2(pgld_pkg::DIV_W + 1);

  logic [pgld_pkg::DIV_W-1:0] dvd_r;
  logic [6:0]                 den_r;
  logic [6:0]                 rem_r;
  logic [CW-1:0]              cnt_r;
  logic                       done_r;
  logic [7:0]                 sh;
  logic                       ge;

  assign sh   = {rem_r, dvd_r[pgld_pkg::DIV_W-1]};
  assign ge   = (sh >= {1'b0, den_r});
  assign done = done_r;
  assign quo  = dvd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= CW'(pgld_pkg::DIV_W);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      den_r <= divisor;
      rem_r <= '0;
    end else if (cnt_r != '0) begin
      rem_r <= ge ? 7'(sh - {1'b0, den_r}) : sh[6:0];
      dvd_r <= {dvd_r[pgld_pkg::DIV_W-2:0], ge};
    end
  end

endmodule

// ----- rtl/pgld_back.sv -----
`timescale 1ns / 1ps
// Back part: gain, limiter, fade-in, fade-out sequencing, statistics, output register.
// Depends on pgld_pkg and pgld_div.
module pgld_back #(
  parameter int MAX_RAMP = pgld_pkg::MAX_RAMP_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  pgld_pkg::cfg_t             cfg,
  input  logic                       q_valid,
  input  pgld_pkg::qent_t            q_rdata,
  output logic                       q_pop,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [pgld_pkg::OUT_W-1:0] out_tdata,
  output logic                       out_tlast
);

  pgld_pkg::bst_t state_r, state_nxt;

  logic        active_r, held_valid_r, neg_r, hit_r, fade_neg_r;
  logic [6:0]  ramp_total_r, ramp_left_r;
  logic signed [15:0] held_r;
  logic [15:0] pk_in_r, pk_out_r, mag_in_r, limit_r, pmag_r, fade_mag_r, q_r;
  logic [31:0] clamp_r, proc_r;
  logic [24:0] prod_r, lprod_r, rq_r;
  logic [5:0]  fade_den_r, fade_num_r;

  logic        out_valid_r, out_last_r;
  logic [pgld_pkg::OUT_W-1:0] out_data_r;

  logic        div_start, div_done, out_load, out_free, fade_ok, ramp_on, last_now;
  logic [24:0] div_a, quo, rm_a;
  logic [49:0] rm_p;
  logic [6:0]  div_b, sat_len, fade_n, rnum;
  logic [15:0] in_mag, smp_val, pk_in_nxt, pk_out_nxt, ld_sample;
  logic [31:0] clamp_nxt, proc_nxt;
  logic        ld_last;

  pgld_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quo      (quo)
  );

  always_comb begin
    if (cfg.fade_len == 7'd0)                 sat_len = 7'd1;
    else if (cfg.fade_len > 7'(MAX_RAMP))     sat_len = 7'(MAX_RAMP);
    else                                      sat_len = cfg.fade_len;
  end

  assign fade_n   = (sat_len < 7'd2) ? 7'd2 : sat_len;
  assign fade_ok  = held_valid_r && (held_r != 16'sd0);
  assign ramp_on  = (ramp_left_r != 7'd0) && (ramp_total_r != 7'd0) &&
                    (ramp_left_r <= ramp_total_r);
  assign rnum     = 7'(ramp_total_r - ramp_left_r + 7'd1);
  assign in_mag   = q_rdata.sample[15] ? 16'(-q_rdata.sample) : q_rdata.sample;
  assign out_free = !out_valid_r || out_tready;
  assign last_now = (fade_num_r == 6'd0);
  assign rm_p     = rm_a * pgld_pkg::PCT_RECIP;

  assign clamp_nxt  = (hit_r && clamp_r != 32'hFFFF_FFFF) ? clamp_r + 32'd1 : clamp_r;
  assign proc_nxt   = (proc_r != 32'hFFFF_FFFF) ? proc_r + 32'd1 : proc_r;
  assign pk_in_nxt  = (mag_in_r > pk_in_r) ? mag_in_r : pk_in_r;
  assign pk_out_nxt = (pmag_r > pk_out_r) ? pmag_r : pk_out_r;
  assign smp_val    = neg_r ? 16'(-pmag_r) : pmag_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pgld_pkg::B_IDLE: begin
        if (q_valid) begin
          unique case (q_rdata.cmd)
            pgld_pkg::CMD_SAMPLE: if (active_r) state_nxt = pgld_pkg::B_LIM_GO;
            pgld_pkg::CMD_FINISH,
            pgld_pkg::CMD_INTR:   if (active_r && fade_ok) state_nxt = pgld_pkg::B_FADE_GO;
            default: ;
          endcase
        end
      end
      pgld_pkg::B_LIM_GO:    state_nxt = pgld_pkg::B_LIM_WAIT;
      pgld_pkg::B_LIM_WAIT:  state_nxt = pgld_pkg::B_SCL_GO;
      pgld_pkg::B_SCL_GO:    state_nxt = pgld_pkg::B_SCL_WAIT;
      pgld_pkg::B_SCL_WAIT:
        state_nxt = ramp_on ? pgld_pkg::B_RMP_GO : pgld_pkg::B_SMP_OUT;
      pgld_pkg::B_RMP_GO:    state_nxt = pgld_pkg::B_RMP_WAIT;
      pgld_pkg::B_RMP_WAIT:  if (div_done) state_nxt = pgld_pkg::B_SMP_OUT;
      pgld_pkg::B_SMP_OUT:   if (out_free) state_nxt = pgld_pkg::B_IDLE;
      pgld_pkg::B_FADE_GO:   state_nxt = pgld_pkg::B_FADE_WAIT;
      pgld_pkg::B_FADE_WAIT: if (div_done) state_nxt = pgld_pkg::B_FADE_OUT;
      pgld_pkg::B_FADE_OUT:
        if (out_free) state_nxt = last_now ? pgld_pkg::B_IDLE : pgld_pkg::B_FADE_GO;
      default: state_nxt = pgld_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = 1'b0;
    div_start = 1'b0;
    div_a     = '0;
    div_b     = '0;
    rm_a      = '0;
    out_load  = 1'b0;
    ld_sample = smp_val;
    ld_last   = 1'b0;
    unique case (state_r)
      pgld_pkg::B_IDLE:   q_pop = q_valid;
      pgld_pkg::B_LIM_GO: rm_a  = lprod_r;
      pgld_pkg::B_SCL_GO: rm_a  = prod_r;
      pgld_pkg::B_RMP_GO: begin
        div_start = 1'b1;
        div_a     = 25'(pmag_r * rnum) + 25'(ramp_total_r >> 1);
        div_b     = ramp_total_r;
      end
      pgld_pkg::B_SMP_OUT: out_load = out_free;
      pgld_pkg::B_FADE_GO: begin
        div_start = 1'b1;
        div_a     = 25'(fade_mag_r * fade_num_r) + 25'(fade_den_r >> 1);
        div_b     = {1'b0, fade_den_r};
      end
      pgld_pkg::B_FADE_OUT: begin
        out_load  = out_free;
        ld_sample = fade_neg_r ? 16'(-q_r) : q_r;
        ld_last   = last_now;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= pgld_pkg::B_IDLE;
      active_r     <= 1'b0;
      ramp_total_r <= '0;
      ramp_left_r  <= '0;
      held_r       <= '0;
      held_valid_r <= 1'b0;
      pk_in_r      <= '0;
      pk_out_r     <= '0;
      clamp_r      <= '0;
      proc_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load)        out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;

      if (state_r == pgld_pkg::B_IDLE && q_valid) begin
        unique case (q_rdata.cmd)
          pgld_pkg::CMD_START:
            if (!active_r) begin
              active_r     <= 1'b1;
              pk_in_r      <= '0;
              pk_out_r     <= '0;
              clamp_r      <= '0;
              proc_r       <= '0;
              held_r       <= '0;
              held_valid_r <= 1'b0;
              ramp_total_r <= sat_len;
              ramp_left_r  <= sat_len;
            end
          pgld_pkg::CMD_FINISH:
            if (active_r) begin
              active_r <= 1'b0;
              if (fade_ok) held_r <= '0;
            end
          pgld_pkg::CMD_INTR: begin
            active_r     <= 1'b0;
            held_r       <= '0;
            held_valid_r <= 1'b0;
            ramp_total_r <= '0;
            ramp_left_r  <= '0;
          end
          default: ;
        endcase
      end
      if (state_r == pgld_pkg::B_RMP_WAIT && div_done) ramp_left_r <= ramp_left_r - 7'd1;
      if (state_r == pgld_pkg::B_SMP_OUT && out_free) begin
        pk_in_r      <= pk_in_nxt;
        pk_out_r     <= pk_out_nxt;
        clamp_r      <= clamp_nxt;
        proc_r       <= proc_nxt;
        held_r       <= smp_val;
        held_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == pgld_pkg::B_IDLE && q_valid) begin
      neg_r      <= q_rdata.sample[15];
      mag_in_r   <= in_mag;
      prod_r     <= 25'(in_mag * cfg.vol);
      lprod_r    <= 25'(cfg.limit_pct * pgld_pkg::FULL_SCALE);
      fade_mag_r <= held_r[15] ? 16'(-held_r) : held_r;
      fade_neg_r <= held_r[15];
      fade_den_r <= 6'(fade_n - 7'd1);
      fade_num_r <= 6'(fade_n - 7'd1);
    end
    if (state_r == pgld_pkg::B_LIM_GO || state_r == pgld_pkg::B_SCL_GO)
      rq_r <= 25'(rm_p >> pgld_pkg::RECIP_SH);
    if (state_r == pgld_pkg::B_LIM_WAIT)
      limit_r <= (cfg.limit_pct == 7'd0 || rq_r > 25'(pgld_pkg::FULL_SCALE)) ?
                 pgld_pkg::FULL_SCALE : rq_r[15:0];
    if (state_r == pgld_pkg::B_SCL_WAIT) begin
      hit_r  <= (rq_r > 25'(limit_r));
      pmag_r <= (rq_r > 25'(limit_r)) ? limit_r : rq_r[15:0];
    end
    if (state_r == pgld_pkg::B_RMP_WAIT && div_done)  pmag_r <= quo[15:0];
    if (state_r == pgld_pkg::B_FADE_WAIT && div_done) q_r    <= quo[15:0];
    if (state_r == pgld_pkg::B_FADE_OUT && out_free && !last_now)
      fade_num_r <= fade_num_r - 6'd1;
    if (out_load) begin
      out_last_r <= ld_last;
      if (state_r == pgld_pkg::B_SMP_OUT)
        out_data_r <= {proc_nxt, clamp_nxt, pk_out_nxt, pk_in_nxt, ld_sample};
      else
        out_data_r <= {proc_r, clamp_r, pk_out_r, pk_in_r, ld_sample};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

// ----- rtl/pcm_gain_limit_declick.sv -----
`timescale 1ns / 1ps
// PCM gain, limiter, fade-in and fade-out (declick) block, top level.
// A sample beat passes the back part's limit, scale and output states; in the fade-in,
// one 25-step serial division of the ramp step is added; gain and limit level use
// reciprocal multiplication. The next queued sample is taken once the last is loaded for output.
// Fade-out: one divider pass per output beat; stalls hold the back part.
// Reset: synchronous, active low; clears control state, statistics and configuration registers.
module pcm_gain_limit_declick #(
  parameter int MAX_RAMP = pgld_pkg::MAX_RAMP_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [15:0]                 in_tdata,   // sample_in
  input  logic [1:0]                  in_tuser,   // command
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // sample_out, peak_in, peak_out, limited_count, samples_done
  output logic [pgld_pkg::OUT_W-1:0]  out_tdata,
  output logic                        out_tlast,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [pgld_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);

  pgld_pkg::qent_t q_wdata, q_rdata;
  pgld_pkg::cfg_t  cfg;
  logic            q_push, q_full, q_pop, q_valid;

  pgld_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_wdata     (q_wdata),
    .cfg         (cfg)
  );

  pgld_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (q_rdata)
  );

  pgld_back #(
    .MAX_RAMP (MAX_RAMP)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .q_valid    (q_valid),
    .q_rdata    (q_rdata),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ----- rtl/pgld_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for the declick block, bound to the top level.
// Depends on pgld_pkg and pcm_gain_limit_declick.
module pgld_sva (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [pgld_pkg::OUT_W-1:0] out_tdata,
  input logic                       out_tlast,
  input logic                       cfg_pready
);

  logic [15:0] so_mag;
  assign so_mag = out_tdata[15] ? 16'(~out_tdata[15:0] + 16'd1) : out_tdata[15:0];

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output beat changed while stalled");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_last_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[15:0] == 16'd0)
    else $error("final fade-out beat not zero");

  a_peak: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> so_mag <= out_tdata[47:32])
    else $error("output sample above output peak");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_pready)
    else $error("config port not ready");

endmodule

bind pcm_gain_limit_declick pgld_sva u_pgld_sva (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .cfg_pready (cfg_pready)
);

// ----- tb/pgld_checker.sv -----
`timescale 1ns / 1ps
// Checker for pcm_gain_limit_declick: snoops the input, result and register ports,
// predicts every result beat and compares it field by field. Depends on pgld_pkg.
module pgld_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,   // sample_in
  input  logic [1:0]  in_tuser,   // command
  input  logic        out_tvalid,
  input  logic        out_tready,
  // sample_out, peak_in, peak_out, limited_count, samples_done
  input  logic [111:0] out_tdata,
  input  logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          fail_count,
  output int          pending
);

  localparam int RAMP_CAP = 64;

  typedef struct {
    logic [15:0] smp;
    logic        lst;
    logic [15:0] pk_in;
    logic [15:0] pk_out;
    logic [31:0] n_clamped;
    logic [31:0] n_samples;
  } pcm_beat_t;

  pcm_beat_t beats_due[$];

  logic [8:0]  vol;
  logic [6:0]  lim_pct;
  logic [6:0]  fade_len;
  bit          streaming;
  int          ramp_total;
  int          ramp_left;
  int          held;
  bit          held_ok;
  logic [15:0] pk_in;
  logic [15:0] pk_out;
  logic [31:0] n_clamped;
  logic [31:0] n_samples;

  assign pending = beats_due.size();

  function automatic int abs_val(int v);
    return v < 0 ? -v : v;
  endfunction

  function automatic int ramp_len();
    int n;
    n = int'(fade_len);
    if (n < 1) n = 1;
    if (n > RAMP_CAP) n = RAMP_CAP;
    return n;
  endfunction

  // v * num / den, rounded half away from zero
  function automatic int scale_round(int v, int num, int den);
    int q;
    if (den == 0 || num >= den) return v;
    q = (abs_val(v) * num + den / 2) / den;
    return v < 0 ? -q : q;
  endfunction

  task automatic push_beat(int s, bit l);
    pcm_beat_t b;
    b.smp       = s[15:0];
    b.lst       = l;
    b.pk_in     = pk_in;
    b.pk_out    = pk_out;
    b.n_clamped = n_clamped;
    b.n_samples = n_samples;
    beats_due.push_back(b);
  endtask

  task automatic fade_to_zero();
    int n;
    if (!held_ok || held == 0) return;
    n = ramp_len();
    if (n < 2) n = 2;
    for (int i = 0; i < n; i++) push_beat(scale_round(held, n - 1 - i, n - 1), i == n - 1);
    held = 0;
  endtask

  task automatic predict(pgld_pkg::cmd_t c, logic signed [15:0] raw);
    int s, scaled, lvl, p;
    s = raw;
    case (c)
      pgld_pkg::CMD_SAMPLE: begin
        if (!streaming) return;
        scaled = (s * int'(vol)) / 100;
        lvl = (32767 * int'(lim_pct)) / 100;
        if (lvl <= 0 || lvl > 32767) lvl = 32767;
        if (scaled > lvl || scaled < -lvl) begin
          scaled = scaled > lvl ? lvl : -lvl;
          if (n_clamped != '1) n_clamped++;
        end
        p = scaled;
        if (ramp_left != 0 && ramp_total != 0 && ramp_left <= ramp_total) begin
          p = scale_round(scaled, ramp_total - ramp_left + 1, ramp_total);
          ramp_left--;
        end
        if (abs_val(s) > int'(pk_in)) pk_in = 16'(abs_val(s));
        if (abs_val(p) > int'(pk_out)) pk_out = 16'(abs_val(p));
        if (n_samples != '1) n_samples++;
        held = p;
        held_ok = 1'b1;
        push_beat(p, 1'b0);
      end
      pgld_pkg::CMD_START: begin
        if (streaming) return;
        streaming = 1'b1;
        pk_in = '0;
        pk_out = '0;
        n_clamped = '0;
        n_samples = '0;
        held = 0;
        held_ok = 1'b0;
        ramp_total = ramp_len();
        ramp_left = ramp_total;
      end
      pgld_pkg::CMD_FINISH: begin
        if (!streaming) return;
        fade_to_zero();
        streaming = 1'b0;
      end
      default: begin
        if (streaming) fade_to_zero();
        streaming = 1'b0;
        held = 0;
        held_ok = 1'b0;
        ramp_total = 0;
        ramp_left = 0;
      end
    endcase
  endtask

  task automatic note_mismatch(string field, longint unsigned want, longint unsigned got);
    fail_count++;
    if (fail_count <= 10)
      $display("%0t mismatch on %s: expected %0h, got %0h", $time, field, want, got);
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    pcm_beat_t b;
    if (!rst_n) begin
      vol = pgld_pkg::VOL_RST;
      lim_pct = pgld_pkg::LIM_RST;
      fade_len = pgld_pkg::FADE_RST;
      streaming = 1'b0;
      ramp_total = 0;
      ramp_left = 0;
      held = 0;
      held_ok = 1'b0;
      pk_in = '0;
      pk_out = '0;
      n_clamped = '0;
      n_samples = '0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (beats_due.size() == 0) begin
          note_mismatch("unexpected beat", 0, out_tdata[15:0]);
        end else begin
          b = beats_due.pop_front();
          if (out_tdata[15:0] !== b.smp) note_mismatch("sample_out", b.smp, out_tdata[15:0]);
          if (out_tlast !== b.lst) note_mismatch("last", b.lst, out_tlast);
          if (out_tdata[31:16] !== b.pk_in) note_mismatch("peak_in", b.pk_in, out_tdata[31:16]);
          if (out_tdata[47:32] !== b.pk_out)
            note_mismatch("peak_out", b.pk_out, out_tdata[47:32]);
          if (out_tdata[79:48] !== b.n_clamped)
            note_mismatch("limited_count", b.n_clamped, out_tdata[79:48]);
          if (out_tdata[111:80] !== b.n_samples)
            note_mismatch("samples_done", b.n_samples, out_tdata[111:80]);
        end
      end
      if (in_tvalid && in_tready) predict(pgld_pkg::cmd_t'(in_tuser), in_tdata);
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (pgld_pkg::reg_t'(cfg_paddr[3:2]))
          pgld_pkg::REG_VOL:  vol = cfg_pwdata[8:0];
          pgld_pkg::REG_LIM:  lim_pct = cfg_pwdata[6:0];
          pgld_pkg::REG_FADE: fade_len = cfg_pwdata[6:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ----- tb/pcm_gain_limit_declick_test.sv -----
`timescale 1ns / 1ps
// Top of the pcm_gain_limit_declick testbench: clock, reset, stimulus, register
// writes and verdict. Depends on pgld_pkg, the block and pgld_checker.
module pcm_gain_limit_declick_test;

  logic         clk = 0;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [15:0]  in_tdata;   // sample_in
  logic [1:0]   in_tuser;   // command
  logic         out_tvalid;
  logic         out_tready;
  logic [111:0] out_tdata;  // sample_out, peak_in, peak_out, limited_count, samples_done
  logic         out_tlast;
  logic         cfg_psel;
  logic         cfg_penable;
  logic         cfg_pwrite;
  logic [3:0]   cfg_paddr;
  logic [31:0]  cfg_pwdata;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;
  int           fail_count;
  int           pending;
  int           burst_left = 0;
  int           stall_pct = 0;
  int           stall_age = 0;

  pcm_gain_limit_declick u_dut (.*);

  pgld_checker u_chk (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  // receiver: stall density is drawn anew whenever its age counter runs out, sometimes none
  always @(posedge clk) begin
    if (stall_age == 0) begin
      stall_age <= $urandom_range(100, 400);
      case ($urandom_range(0, 3))
        0: stall_pct <= 0;
        1: stall_pct <= 25;
        2: stall_pct <= 60;
        default: stall_pct <= 90;
      endcase
    end else begin
      stall_age <= stall_age - 1;
    end
    out_tready <= rst_n && ($urandom_range(0, 99) >= stall_pct);
  end

  task automatic send_beat(pgld_pkg::cmd_t c, logic [15:0] s);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_tvalid <= 0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    in_tvalid <= 1;
    in_tuser  <= c;
    in_tdata  <= s;
    @(negedge clk);
    while (!in_tready) @(negedge clk);
    @(posedge clk);
    burst_left--;
  endtask

  task automatic drain();
    in_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(pgld_pkg::reg_t r, logic [31:0] v);
    cfg_psel    <= 1;
    cfg_penable <= 0;
    cfg_pwrite  <= 1;
    cfg_paddr   <= {r, 2'b00};
    cfg_pwdata  <= v;
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    cfg_psel    <= 0;
    cfg_penable <= 0;
  endtask

  task automatic set_regs(int v, int l, int f);
    write_reg(pgld_pkg::REG_VOL, v);
    write_reg(pgld_pkg::REG_LIM, l);
    write_reg(pgld_pkg::REG_FADE, f);
  endtask

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic random_phase(int items);
    int sent, k;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(0, 9) < 8) begin
        send_beat(pgld_pkg::CMD_START, 16'($urandom_range(0, 65535)));
        k = $urandom_range(1, 12);
        for (int i = 0; i < k; i++) begin
          if ($urandom_range(0, 19) == 0)
            send_beat(pgld_pkg::CMD_START, 16'($urandom_range(0, 65535)));
          else send_beat(pgld_pkg::CMD_SAMPLE, pick_sample());
        end
        if ($urandom_range(0, 9) < 6)
          send_beat(pgld_pkg::CMD_FINISH, 16'($urandom_range(0, 65535)));
        else send_beat(pgld_pkg::CMD_INTR, 16'($urandom_range(0, 65535)));
        sent += k + 2;
      end else begin
        send_beat(pgld_pkg::cmd_t'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)));
        sent++;
      end
    end
  endtask

  initial begin
    #40_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    rst_n       <= 0;
    in_tvalid   <= 0;
    in_tdata    <= 0;
    in_tuser    <= pgld_pkg::CMD_SAMPLE;
    cfg_psel    <= 0;
    cfg_penable <= 0;
    cfg_pwrite  <= 0;
    cfg_paddr   <= 0;
    cfg_pwdata  <= 0;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // idle commands, double start, extremes, finish with and without held sample
    send_beat(pgld_pkg::CMD_SAMPLE, 16'd100);
    send_beat(pgld_pkg::CMD_FINISH, 16'd0);
    send_beat(pgld_pkg::CMD_INTR, 16'd0);
    send_beat(pgld_pkg::CMD_START, 16'd0);
    send_beat(pgld_pkg::CMD_START, 16'd0);
    send_beat(pgld_pkg::CMD_SAMPLE, 16'h7FFF);
    send_beat(pgld_pkg::CMD_SAMPLE, 16'h8000);
    send_beat(pgld_pkg::CMD_SAMPLE, 16'h0001);
    send_beat(pgld_pkg::CMD_SAMPLE, 16'hFFFF);
    send_beat(pgld_pkg::CMD_FINISH, 16'd0);
    send_beat(pgld_pkg::CMD_FINISH, 16'd0);
    drain();
    set_regs(511, 1, 0);
    send_beat(pgld_pkg::CMD_START, 16'd0);
    send_beat(pgld_pkg::CMD_SAMPLE, 16'h7FFF);
    send_beat(pgld_pkg::CMD_SAMPLE, 16'h8000);
    send_beat(pgld_pkg::CMD_SAMPLE, 16'hB1E0);
    send_beat(pgld_pkg::CMD_INTR, 16'd0);
    send_beat(pgld_pkg::CMD_START, 16'd0);
    send_beat(pgld_pkg::CMD_SAMPLE, 16'h0000);
    send_beat(pgld_pkg::CMD_FINISH, 16'd0);
    send_beat(pgld_pkg::CMD_START, 16'd0);
    send_beat(pgld_pkg::CMD_FINISH, 16'd0);
    drain();

    set_regs(0, 127, 127);
    random_phase(15);
    drain();
    set_regs(400, 100, 64);
    random_phase(18);
    drain();
    set_regs(150, 50, 8);
    random_phase(18);
    drain();
    set_regs(511, 0, 3);
    random_phase(18);
    drain();
    set_regs(100, 100, 2);
    random_phase(18);
    drain();

    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
